// ----- rtl/drf_pkg.sv -----
`timescale 1ns / 1ps
package drf_pkg;

   localparam int RING_DEPTH = 2048;
   localparam int MAX_READ   = 64;
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int CNT_W      = $clog2(MAX_READ + 1);
   localparam int REQ_CNT_W  = 7;
   localparam int TOTAL_W    = 32;

   localparam logic [7:0] PREAMBLE_BYTE = 8'hD3;
   localparam logic [7:0] SYNC_LEAD     = 8'hB5;
   localparam logic [7:0] SYNC_TAIL     = 8'h62;

   localparam logic [1:0] FUNC_PUSH1  = 2'd0;
   localparam logic [1:0] FUNC_PUSH2  = 2'd1;
   localparam logic [1:0] FUNC_READ   = 2'd2;
   localparam logic [1:0] FUNC_RESET1 = 2'd3;

   typedef struct packed {
      logic       push1;
      logic       push2;
      logic       clr1;
      logic [7:0] data;
   } cnt_ctrl_type;

   typedef struct packed {
      logic valid;
      logic byte_valid;
      logic last;
      logic chan;
   } rsp_ctrl_type;

endpackage

// ----- rtl/dual_rx_fifo_with_sync_counters.sv -----
`timescale 1ns / 1ps
// Push and channel-reset transactions: executed the cycle after acceptance, status strobe next.
// Read transaction: after the exec state, one byte per cycle up to 64, else a status strobe.
// A new transaction is accepted only in idle, after the previous one gave its last strobe.
// The receiver cannot stall: every strobe lasts exactly one cycle.
// Synchronous active-high reset clears pointers, counters and read channel; stores stay as is.
module dual_rx_fifo_with_sync_counters import drf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [1:0]           req_func,
   input  logic [7:0]           req_data_byte,
   input  logic [REQ_CNT_W-1:0] req_read_count,
   output logic                 rsp_valid,
   output logic [7:0]           rsp_byte_data,
   output logic                 rsp_byte_valid,
   output logic                 rsp_last,
   output logic [TOTAL_W-1:0]   rsp_first_channel_total,
   output logic [TOTAL_W-1:0]   rsp_second_channel_total,
   output logic [TOTAL_W-1:0]   rsp_sync_pair_total,
   output logic [TOTAL_W-1:0]   rsp_first_preamble_total,
   output logic [TOTAL_W-1:0]   rsp_second_preamble_total,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_read_channel
);

   cnt_ctrl_type     cnt_ctrl;
   rsp_ctrl_type     rsp_ctrl;
   logic             we1, we2;
   logic [PTR_W-1:0] addr1, addr2;
   logic [7:0]       wdata, rdata1, rdata2;

   drf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .func       (req_func),
      .data_byte  (req_data_byte),
      .read_count (req_read_count),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_read_channel),
      .csr_ready  (csr_ready),
      .busy       (busy),
      .cnt_ctrl   (cnt_ctrl),
      .rsp_ctrl   (rsp_ctrl),
      .we1        (we1),
      .addr1      (addr1),
      .we2        (we2),
      .addr2      (addr2),
      .wdata      (wdata)
   );

   drf_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram1 (
      .clock (clock),
      .we    (we1),
      .addr  (addr1),
      .wdata (wdata),
      .rdata (rdata1)
   );

   drf_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ram2 (
      .clock (clock),
      .we    (we2),
      .addr  (addr2),
      .wdata (wdata),
      .rdata (rdata2)
   );

   drf_counters u_counters (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (cnt_ctrl),
      .first_total      (rsp_first_channel_total),
      .second_total     (rsp_second_channel_total),
      .sync_total       (rsp_sync_pair_total),
      .first_pre_total  (rsp_first_preamble_total),
      .second_pre_total (rsp_second_preamble_total)
   );

   assign rsp_valid      = rsp_ctrl.valid;
   assign rsp_byte_valid = rsp_ctrl.byte_valid;
   assign rsp_last       = rsp_ctrl.last;
   assign rsp_byte_data  = !rsp_ctrl.byte_valid ? 8'd0 : (rsp_ctrl.chan ? rdata2 : rdata1);

endmodule

// ----- rtl/drf_ram.sv -----
`timescale 1ns / 1ps
module drf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/drf_counters.sv -----
`timescale 1ns / 1ps
module drf_counters import drf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cnt_ctrl_type       ctrl,
   output logic [TOTAL_W-1:0] first_total,
   output logic [TOTAL_W-1:0] second_total,
   output logic [TOTAL_W-1:0] sync_total,
   output logic [TOTAL_W-1:0] first_pre_total,
   output logic [TOTAL_W-1:0] second_pre_total
);

   logic [TOTAL_W-1:0] first_total_ff, first_total_in;
   logic [TOTAL_W-1:0] second_total_ff, second_total_in;
   logic [TOTAL_W-1:0] sync_total_ff, sync_total_in;
   logic [TOTAL_W-1:0] first_pre_ff, first_pre_in;
   logic [TOTAL_W-1:0] second_pre_ff, second_pre_in;
   logic               saw_lead_ff, saw_lead_in;

   always_comb begin
      first_total_in  = first_total_ff;
      second_total_in = second_total_ff;
      sync_total_in   = sync_total_ff;
      first_pre_in    = first_pre_ff;
      second_pre_in   = second_pre_ff;
      saw_lead_in     = saw_lead_ff;
      if (ctrl.push1) begin
         first_total_in = first_total_ff + 1'b1;
         if (ctrl.data == PREAMBLE_BYTE) begin
            first_pre_in = first_pre_ff + 1'b1;
         end
         if (saw_lead_ff && ctrl.data == SYNC_TAIL) begin
            sync_total_in = sync_total_ff + 1'b1;
         end
         saw_lead_in = (ctrl.data == SYNC_LEAD);
      end
      if (ctrl.push2) begin
         second_total_in = second_total_ff + 1'b1;
         if (ctrl.data == PREAMBLE_BYTE) begin
            second_pre_in = second_pre_ff + 1'b1;
         end
      end
      if (ctrl.clr1) begin
         first_total_in = '0;
         sync_total_in  = '0;
         first_pre_in   = '0;
         saw_lead_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_total_ff  <= '0;
         second_total_ff <= '0;
         sync_total_ff   <= '0;
         first_pre_ff    <= '0;
         second_pre_ff   <= '0;
         saw_lead_ff     <= 1'b0;
      end else begin
         first_total_ff  <= first_total_in;
         second_total_ff <= second_total_in;
         sync_total_ff   <= sync_total_in;
         first_pre_ff    <= first_pre_in;
         second_pre_ff   <= second_pre_in;
         saw_lead_ff     <= saw_lead_in;
      end
   end

   assign first_total      = first_total_ff;
   assign second_total     = second_total_ff;
   assign sync_total       = sync_total_ff;
   assign first_pre_total  = first_pre_ff;
   assign second_pre_total = second_pre_ff;

endmodule

// ----- rtl/drf_ctrl.sv -----
`timescale 1ns / 1ps
module drf_ctrl import drf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [1:0]           func,
   input  logic [7:0]           data_byte,
   input  logic [REQ_CNT_W-1:0] read_count,
   input  logic                 csr_valid,
   input  logic                 csr_wdata,
   output logic                 csr_ready,
   output logic                 busy,
   output cnt_ctrl_type         cnt_ctrl,
   output rsp_ctrl_type         rsp_ctrl,
   output logic                 we1,
   output logic [PTR_W-1:0]     addr1,
   output logic                 we2,
   output logic [PTR_W-1:0]     addr2,
   output logic [7:0]           wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       func_ff, func_in;
   logic [7:0]       data_ff, data_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic             chan_ff, chan_in;
   logic [PTR_W-1:0] wr1_ff, wr1_in, rd1_ff, rd1_in;
   logic [PTR_W-1:0] wr2_ff, wr2_in, rd2_ff, rd2_in;

   logic [PTR_W-1:0] rd_sel, wr_sel, ptr_cur, ptr_next, ptr_cmp;
   logic             ptr_hit, empty, full, pop, last_pop;

   assign rd_sel = chan_ff ? rd2_ff : rd1_ff;
   assign wr_sel = chan_ff ? wr2_ff : wr1_ff;
   assign empty  = (rd_sel == wr_sel);

   // shared ring-pointer unit: one incrementer and one compare
   always_comb begin
      case (func_ff)
         FUNC_PUSH1: begin
            ptr_cur = wr1_ff;
            ptr_cmp = rd1_ff;
         end
         FUNC_PUSH2: begin
            ptr_cur = wr2_ff;
            ptr_cmp = rd2_ff;
         end
         default: begin
            ptr_cur = rd_sel;
            ptr_cmp = wr_sel;
         end
      endcase
      ptr_next = (ptr_cur == PTR_W'(RING_DEPTH - 1)) ? '0 : ptr_cur + 1'b1;
      ptr_hit  = (ptr_next == ptr_cmp);
   end

   assign full     = ptr_hit;
   assign last_pop = (remain_ff == '0) || empty;

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      data_in   = data_ff;
      remain_in = remain_ff;
      chan_in   = chan_ff;
      wr1_in    = wr1_ff;
      rd1_in    = rd1_ff;
      wr2_in    = wr2_ff;
      rd2_in    = rd2_ff;
      cnt_ctrl  = '{push1: 1'b0, push2: 1'b0, clr1: 1'b0, data: data_ff};
      rsp_ctrl  = '{valid: 1'b0, byte_valid: 1'b0, last: 1'b0, chan: chan_ff};
      we1       = 1'b0;
      we2       = 1'b0;
      pop       = 1'b0;
      if (csr_valid && csr_ready) begin
         chan_in = csr_wdata;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in   = func;
               data_in   = data_byte;
               remain_in = (read_count > REQ_CNT_W'(MAX_READ)) ?
                           CNT_W'(MAX_READ) : CNT_W'(read_count);
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
            case (func_ff)
               FUNC_PUSH1: begin
                  cnt_ctrl.push1 = 1'b1;
                  if (!full) begin
                     we1    = 1'b1;
                     wr1_in = ptr_next;
                  end
               end
               FUNC_PUSH2: begin
                  cnt_ctrl.push2 = 1'b1;
                  if (!full) begin
                     we2    = 1'b1;
                     wr2_in = ptr_next;
                  end
               end
               FUNC_RESET1: begin
                  cnt_ctrl.clr1 = 1'b1;
                  wr1_in        = '0;
                  rd1_in        = '0;
               end
               default: begin
                  if (!last_pop) begin
                     pop      = 1'b1;
                     state_in = ST_READ;
                  end
               end
            endcase
         end
         ST_READ: begin
            rsp_ctrl.valid      = 1'b1;
            rsp_ctrl.byte_valid = 1'b1;
            rsp_ctrl.last       = last_pop;
            if (last_pop) begin
               state_in = ST_IDLE;
            end else begin
               pop = 1'b1;
            end
         end
         ST_DONE: begin
            rsp_ctrl.valid = 1'b1;
            rsp_ctrl.last  = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (pop) begin
         remain_in = remain_ff - 1'b1;
         if (chan_ff) begin
            rd2_in = ptr_next;
         end else begin
            rd1_in = ptr_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= 1'b0;
         wr1_ff   <= '0;
         rd1_ff   <= '0;
         wr2_ff   <= '0;
         rd2_ff   <= '0;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         wr1_ff   <= wr1_in;
         rd1_ff   <= rd1_in;
         wr2_ff   <= wr2_in;
         rd2_ff   <= rd2_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      data_ff   <= data_in;
      remain_ff <= remain_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = !busy;
   assign addr1     = (func_ff == FUNC_PUSH1) ? wr1_ff : rd1_ff;
   assign addr2     = (func_ff == FUNC_PUSH2) ? wr2_ff : rd2_ff;
   assign wdata     = data_ff;

endmodule

// ----- rtl/drf_checker.sv -----
`timescale 1ns / 1ps
module drf_checker import drf_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic                 rsp_valid,
   input logic [7:0]           rsp_byte_data,
   input logic                 rsp_byte_valid,
   input logic                 rsp_last,
   input logic                 csr_valid,
   input logic                 csr_ready
);

   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a transaction");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("accepted transaction did not raise busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |=> !busy && !rsp_valid)
      else $error("busy held past final result");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_last && rsp_byte_data == 8'd0)
      else $error("status result not final or carries data");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !busy)
      else $error("register write taken while busy");

endmodule

bind dual_rx_fifo_with_sync_counters drf_checker u_drf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_byte_data  (rsp_byte_data),
   .rsp_byte_valid (rsp_byte_valid),
   .rsp_last       (rsp_last),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);

// ----- verif/rx_fifo_checker.sv -----
`timescale 1ns / 1ps
module rx_fifo_checker import drf_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [1:0]           req_func,
   input  logic [7:0]           req_data_byte,
   input  logic [REQ_CNT_W-1:0] req_read_count,
   input  logic                 rsp_valid,
   input  logic [7:0]           rsp_byte_data,
   input  logic                 rsp_byte_valid,
   input  logic                 rsp_last,
   input  logic [TOTAL_W-1:0]   rsp_first_channel_total,
   input  logic [TOTAL_W-1:0]   rsp_second_channel_total,
   input  logic [TOTAL_W-1:0]   rsp_sync_pair_total,
   input  logic [TOTAL_W-1:0]   rsp_first_preamble_total,
   input  logic [TOTAL_W-1:0]   rsp_second_preamble_total,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic                 csr_read_channel,
   output int                   errors,
   output int                   pending
);

   typedef struct packed {
      logic [7:0]         data;
      logic               data_valid;
      logic               last;
      logic [TOTAL_W-1:0] rx1_total;
      logic [TOTAL_W-1:0] rx2_total;
      logic [TOTAL_W-1:0] sync_pairs;
      logic [TOTAL_W-1:0] preamble1;
      logic [TOTAL_W-1:0] preamble2;
   } rx_status_type;

   logic [7:0]         ring1 [RING_DEPTH];
   logic [7:0]         ring2 [RING_DEPTH];
   logic [PTR_W-1:0]   wr1, rd1, wr2, rd2;
   logic [TOTAL_W-1:0] rx1_total, rx2_total, sync_pairs, preamble1, preamble2;
   logic               lead_seen;
   logic               drain_second;
   rx_status_type      status_q [$];
   rx_status_type      oldest;
   int                 err_count = 0;

   function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic rx_status_type make_status(input logic [7:0] b, input logic vld,
                                                 input logic lst);
      rx_status_type s;
      s.data       = b;
      s.data_valid = vld;
      s.last       = lst;
      s.rx1_total  = rx1_total;
      s.rx2_total  = rx2_total;
      s.sync_pairs = sync_pairs;
      s.preamble1  = preamble1;
      s.preamble2  = preamble2;
      return s;
   endfunction

   task automatic clear_first_channel();
      wr1        = '0;
      rd1        = '0;
      rx1_total  = '0;
      sync_pairs = '0;
      preamble1  = '0;
      lead_seen  = 1'b0;
   endtask

   task automatic predict_transaction(input logic [1:0] func, input logic [7:0] b,
                                      input logic [REQ_CNT_W-1:0] want);
      int            limit;
      int            n;
      logic [7:0]    popped;
      rx_status_type tail;
      limit = (want > MAX_READ) ? MAX_READ : int'(want);
      n     = 0;
      case (func)
         FUNC_PUSH1: begin
            rx1_total += 1;
            if (b == PREAMBLE_BYTE) preamble1 += 1;
            if (lead_seen && b == SYNC_TAIL) sync_pairs += 1;
            lead_seen = (b == SYNC_LEAD);
            if (ring_advance(wr1) != rd1) begin
               ring1[wr1] = b;
               wr1 = ring_advance(wr1);
            end
         end
         FUNC_PUSH2: begin
            rx2_total += 1;
            if (b == PREAMBLE_BYTE) preamble2 += 1;
            if (ring_advance(wr2) != rd2) begin
               ring2[wr2] = b;
               wr2 = ring_advance(wr2);
            end
         end
         FUNC_RESET1: begin
            clear_first_channel();
         end
         FUNC_READ: begin
            while (n < limit && (drain_second ? (rd2 != wr2) : (rd1 != wr1))) begin
               if (drain_second) begin
                  popped = ring2[rd2];
                  rd2 = ring_advance(rd2);
               end else begin
                  popped = ring1[rd1];
                  rd1 = ring_advance(rd1);
               end
               n++;
               status_q.push_back(make_status(popped, 1'b1, 1'b0));
            end
         end
      endcase
      if (n == 0) begin
         status_q.push_back(make_status(8'h00, 1'b0, 1'b1));
      end else begin
         tail = status_q.pop_back();
         tail.last = 1'b1;
         status_q.push_back(tail);
      end
   endtask

   task automatic compare_field(input string name, input logic [TOTAL_W-1:0] want,
                                input logic [TOTAL_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_first_channel();
         wr2          = '0;
         rd2          = '0;
         rx2_total    = '0;
         preamble2    = '0;
         drain_second = 1'b0;
         status_q.delete();
      end else begin
         if (rsp_valid) begin
            if (status_q.size() == 0) begin
               $display("%0t: unexpected result strobe, expected none actual %0h",
                        $time, rsp_byte_data);
               err_count++;
            end else begin
               oldest = status_q.pop_front();
               compare_field("byte_data", TOTAL_W'(oldest.data), TOTAL_W'(rsp_byte_data));
               compare_field("byte_valid", TOTAL_W'(oldest.data_valid),
                             TOTAL_W'(rsp_byte_valid));
               compare_field("last", TOTAL_W'(oldest.last), TOTAL_W'(rsp_last));
               compare_field("first_channel_total", oldest.rx1_total, rsp_first_channel_total);
               compare_field("second_channel_total", oldest.rx2_total,
                             rsp_second_channel_total);
               compare_field("sync_pair_total", oldest.sync_pairs, rsp_sync_pair_total);
               compare_field("first_preamble_total", oldest.preamble1,
                             rsp_first_preamble_total);
               compare_field("second_preamble_total", oldest.preamble2,
                             rsp_second_preamble_total);
            end
         end
         if (csr_valid && csr_ready) drain_second = csr_read_channel;
         if (start && !busy) predict_transaction(req_func, req_data_byte, req_read_count);
      end
      errors  <= err_count;
      pending <= status_q.size();
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import drf_pkg::*;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 start            = 1'b0;
   logic [1:0]           req_func         = FUNC_PUSH1;
   logic [7:0]           req_data_byte    = 8'h00;
   logic [REQ_CNT_W-1:0] req_read_count   = '0;
   logic                 csr_valid        = 1'b0;
   logic                 csr_read_channel = 1'b0;
   logic                 busy;
   logic                 csr_ready;
   logic                 rsp_valid;
   logic [7:0]           rsp_byte_data;
   logic                 rsp_byte_valid;
   logic                 rsp_last;
   logic [TOTAL_W-1:0]   rsp_first_channel_total;
   logic [TOTAL_W-1:0]   rsp_second_channel_total;
   logic [TOTAL_W-1:0]   rsp_sync_pair_total;
   logic [TOTAL_W-1:0]   rsp_first_preamble_total;
   logic [TOTAL_W-1:0]   rsp_second_preamble_total;
   int                   errors;
   int                   pending;
   int                   items_sent    = 0;
   int                   settings_used = 0;
   bit                   no_idle       = 1'b0;

   always #10 clock = ~clock;

   dual_rx_fifo_with_sync_counters DUT (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_func                  (req_func),
      .req_data_byte             (req_data_byte),
      .req_read_count            (req_read_count),
      .rsp_valid                 (rsp_valid),
      .rsp_byte_data             (rsp_byte_data),
      .rsp_byte_valid            (rsp_byte_valid),
      .rsp_last                  (rsp_last),
      .rsp_first_channel_total   (rsp_first_channel_total),
      .rsp_second_channel_total  (rsp_second_channel_total),
      .rsp_sync_pair_total       (rsp_sync_pair_total),
      .rsp_first_preamble_total  (rsp_first_preamble_total),
      .rsp_second_preamble_total (rsp_second_preamble_total),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_read_channel          (csr_read_channel)
   );

   rx_fifo_checker fifo_check (
      .clock                     (clock),
      .reset                     (reset),
      .start                     (start),
      .busy                      (busy),
      .req_func                  (req_func),
      .req_data_byte             (req_data_byte),
      .req_read_count            (req_read_count),
      .rsp_valid                 (rsp_valid),
      .rsp_byte_data             (rsp_byte_data),
      .rsp_byte_valid            (rsp_byte_valid),
      .rsp_last                  (rsp_last),
      .rsp_first_channel_total   (rsp_first_channel_total),
      .rsp_second_channel_total  (rsp_second_channel_total),
      .rsp_sync_pair_total       (rsp_sync_pair_total),
      .rsp_first_preamble_total  (rsp_first_preamble_total),
      .rsp_second_preamble_total (rsp_second_preamble_total),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_read_channel          (csr_read_channel),
      .errors                    (errors),
      .pending                   (pending)
   );

   task automatic drive_item(input logic [1:0] func, input logic [7:0] data,
                             input logic [REQ_CNT_W-1:0] count);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_func       <= func;
      req_data_byte  <= data;
      req_read_count <= count;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // drain everything in flight before touching the register
   task automatic write_read_channel(input logic sel);
      int gap;
      gap = $urandom_range(0, 11);
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4 + gap) @(posedge clock);
      csr_valid        <= 1'b1;
      csr_read_channel <= sel;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic logic [7:0] random_byte();
      int pick;
      pick = $urandom_range(0, 11);
      case (pick)
         0:       return PREAMBLE_BYTE;
         1:       return SYNC_LEAD;
         2:       return SYNC_TAIL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [REQ_CNT_W-1:0] random_count();
      int pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0:       return '0;
         1:       return REQ_CNT_W'($urandom_range(MAX_READ + 1, 127));
         2:       return REQ_CNT_W'(MAX_READ);
         3:       return REQ_CNT_W'($urandom_range(17, MAX_READ));
         default: return REQ_CNT_W'($urandom_range(1, 16));
      endcase
   endfunction

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         if ($urandom_range(0, 3) == 0) begin
            drive_item(FUNC_PUSH1, SYNC_LEAD, 7'($urandom));
            drive_item(FUNC_PUSH1, SYNC_TAIL, 7'($urandom));
         end else begin
            drive_item(FUNC_PUSH1, random_byte(), 7'($urandom));
         end
      end else if (pick < 60) begin
         drive_item(FUNC_PUSH2, random_byte(), 7'($urandom));
      end else if (pick < 92) begin
         drive_item(FUNC_READ, 8'($urandom), random_count());
      end else begin
         drive_item(FUNC_RESET1, 8'($urandom), 7'($urandom));
      end
   endtask

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int i;
      int phase;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      write_read_channel(1'b0);
      drive_item(FUNC_READ, 8'h00, 7'd5);
      drive_item(FUNC_PUSH1, 8'h00, 7'd0);
      drive_item(FUNC_PUSH1, 8'hFF, 7'h7F);
      drive_item(FUNC_PUSH1, SYNC_LEAD, 7'd0);
      drive_item(FUNC_PUSH1, SYNC_TAIL, 7'd0);
      drive_item(FUNC_PUSH1, PREAMBLE_BYTE, 7'd0);
      drive_item(FUNC_PUSH1, SYNC_LEAD, 7'd0);
      drive_item(FUNC_PUSH1, SYNC_LEAD, 7'd0);
      drive_item(FUNC_PUSH1, SYNC_TAIL, 7'd0);
      drive_item(FUNC_PUSH2, PREAMBLE_BYTE, 7'd0);
      drive_item(FUNC_PUSH2, 8'hFF, 7'd0);
      drive_item(FUNC_PUSH2, 8'h00, 7'd0);
      drive_item(FUNC_READ, 8'hFF, 7'd0);
      drive_item(FUNC_READ, 8'h00, 7'd3);
      drive_item(FUNC_READ, 8'h00, 7'h7F);
      // sync state must not survive a channel reset
      drive_item(FUNC_PUSH1, SYNC_LEAD, 7'd0);
      drive_item(FUNC_RESET1, 8'hFF, 7'h7F);
      drive_item(FUNC_PUSH1, SYNC_TAIL, 7'd0);
      drive_item(FUNC_READ, 8'h00, 7'd4);
      write_read_channel(1'b1);
      drive_item(FUNC_READ, 8'h00, 7'(MAX_READ));
      drive_item(FUNC_READ, 8'h00, 7'd1);
      drive_item(FUNC_RESET1, 8'h00, 7'd0);

      for (phase = 0; phase < 6; phase++) begin
         write_read_channel(phase[0]);
         no_idle = (phase == 3);
         for (i = 0; i < 50; i++) random_item();
      end
      no_idle = 1'b0;

      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Covered %0d transactions over %0d read-channel settings,", items_sent,
               settings_used);
      $display("with mixed pushes, sync pairs, saturated and empty reads, and channel resets.");
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/drf_pkg.sv
rtl/drf_ram.sv
rtl/drf_counters.sv
rtl/drf_ctrl.sv
rtl/dual_rx_fifo_with_sync_counters.sv
rtl/drf_checker.sv
verif/rx_fifo_checker.sv
verif/testbench.sv
